[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the heading pipeline modules.
// Each macro expects i_clk and i_rst_n to be visible in the module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/chxy_pkg.sv]
// ----------------------------------------------------------------------------
// chxy_pkg
// Shared constants, arctangent table and control type for the heading block.
// ----------------------------------------------------------------------------
`default_nettype none

package chxy_pkg;

    // Binary angle: 2^32 is one full turn
    localparam int ANGLE_BITS  = 32;
    localparam int GUARD_BITS  = 24;
    localparam int TABLE_LEN   = 24;
    localparam int TABLE_IDX_W = $clog2(TABLE_LEN);

    localparam logic [ANGLE_BITS-1:0] ANG_ZERO = 32'h0000_0000;
    localparam logic [ANGLE_BITS-1:0] ANG_HALF = 32'h8000_0000;

    // atan(2^-i) as a binary angle, rounded to nearest
    localparam logic [ANGLE_BITS-1:0] ARC_TABLE [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Control that travels with each beat down the pipeline
    typedef struct packed {
        logic valid;
        logic y_zero;
        logic x_neg;
    } t_ctl;

endpackage

`default_nettype wire

[rtl/chxy_prerot.sv]
// ----------------------------------------------------------------------------
// chxy_prerot
// Input stage: sign-extend the readings, turn the vector into the right
// half-plane and scale by the guard bits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module chxy_prerot #(
    parameter int SAMPLE_BITS = 16,
    parameter int DW          = 43
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic signed [SAMPLE_BITS-1:0] i_field_x,
    input  wire logic signed [SAMPLE_BITS-1:0] i_field_y,
    output logic signed [DW-1:0]               o_x,
    output logic signed [DW-1:0]               o_y,
    output logic [chxy_pkg::ANGLE_BITS-1:0]    o_ang,
    output chxy_pkg::t_ctl                     o_ctl
);
    import chxy_pkg::*;

    logic signed [DW-1:0]   w_xe;
    logic signed [DW-1:0]   w_ye;
    logic                   w_neg;
    logic signed [DW-1:0]   n_x;
    logic signed [DW-1:0]   n_y;
    logic [ANGLE_BITS-1:0]  n_ang;
    t_ctl                   n_ctl;
    logic signed [DW-1:0]   r_x;
    logic signed [DW-1:0]   r_y;
    logic [ANGLE_BITS-1:0]  r_ang;
    t_ctl                   r_ctl;

    // Extend, flip into the right half-plane, add guard bits
    always_comb begin
        w_xe         = DW'(i_field_x);
        w_ye         = DW'(i_field_y);
        w_neg        = i_field_x[SAMPLE_BITS-1];
        n_x          = (w_neg ? -w_xe : w_xe) <<< GUARD_BITS;
        n_y          = (w_neg ? -w_ye : w_ye) <<< GUARD_BITS;
        n_ang        = w_neg ? ANG_HALF : ANG_ZERO;
        n_ctl.valid  = i_start;
        n_ctl.y_zero = (i_field_y == '0);
        n_ctl.x_neg  = w_neg;
    end

    // Register the beat's control, cleared under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    // Capture the data
    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_ang <= n_ang;
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_ang = r_ang;
    assign o_ctl = r_ctl;

    `CHK_NEXT(a_neg_seed, i_start && w_neg, o_ang == ANG_HALF && o_ctl.x_neg, "seed lost")

endmodule

`default_nettype wire

[rtl/chxy_cordic_stage.sv]
// ----------------------------------------------------------------------------
// chxy_cordic_stage
// One registered vectoring micro-rotation: drive y towards zero and
// accumulate the matching arctangent.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module chxy_cordic_stage #(
    parameter int DW    = 43,
    parameter int STAGE = 0
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic signed [DW-1:0]             i_x,
    input  wire logic signed [DW-1:0]             i_y,
    input  wire logic [chxy_pkg::ANGLE_BITS-1:0]  i_ang,
    input  wire chxy_pkg::t_ctl                   i_ctl,
    output logic signed [DW-1:0]                  o_x,
    output logic signed [DW-1:0]                  o_y,
    output logic [chxy_pkg::ANGLE_BITS-1:0]       o_ang,
    output chxy_pkg::t_ctl                        o_ctl
);
    import chxy_pkg::*;

    localparam logic [TABLE_IDX_W-1:0] IDX = TABLE_IDX_W'(STAGE);

    logic signed [DW-1:0]   w_xs;
    logic signed [DW-1:0]   w_ys;
    logic signed [DW-1:0]   n_x;
    logic signed [DW-1:0]   n_y;
    logic [ANGLE_BITS-1:0]  n_ang;
    logic signed [DW-1:0]   r_x;
    logic signed [DW-1:0]   r_y;
    logic [ANGLE_BITS-1:0]  r_ang;
    t_ctl                   r_ctl;

    // Rotate by +/- atan(2^-STAGE) depending on the sign of y
    always_comb begin
        w_xs = i_x >>> STAGE;
        w_ys = i_y >>> STAGE;
        if (!i_y[DW-1]) begin
            n_x   = i_x + w_ys;
            n_y   = i_y - w_xs;
            n_ang = i_ang + ARC_TABLE[IDX];
        end else begin
            n_x   = i_x - w_ys;
            n_y   = i_y + w_xs;
            n_ang = i_ang - ARC_TABLE[IDX];
        end
    end

    // Advance the control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // Advance the data
    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_ang <= n_ang;
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_ang = r_ang;
    assign o_ctl = r_ctl;

    `CHK_NEXT(a_stage_valid, i_ctl.valid, o_ctl.valid, "beat dropped in rotation stage")

endmodule

`default_nettype wire

[rtl/chxy_scale.sv]
// ----------------------------------------------------------------------------
// chxy_scale
// Output stages: scale the binary angle to degrees, round to nearest, wrap
// a full turn to zero and apply the y-zero special cases.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module chxy_scale #(
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int HW              = 15
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [chxy_pkg::ANGLE_BITS-1:0]  i_ang,
    input  wire chxy_pkg::t_ctl                   i_ctl,
    output logic                                  o_valid,
    output logic [HW-1:0]                         o_heading
);
    import chxy_pkg::*;

    localparam int           PW   = ANGLE_BITS + HW;
    localparam logic [HW-1:0] FULL = HW'(360 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [HW-1:0] HALF = HW'(180 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [PW-1:0] RND  = PW'(ANG_HALF);

    logic [PW-1:0] r_prod;
    t_ctl          r_ctl;
    logic [PW-1:0] w_sum;
    logic [HW-1:0] w_h;
    logic [HW-1:0] n_heading;
    logic [HW-1:0] r_heading;
    logic          r_valid;

    // Stage one: multiply by a full turn in output units
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_ang) * PW'(FULL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // Stage two: round, wrap, pick the axis cases
    always_comb begin
        w_sum = r_prod + RND;
        w_h   = w_sum[PW-1:ANGLE_BITS];
        if (r_ctl.y_zero) begin
            n_heading = r_ctl.x_neg ? HALF : '0;
        end else if (w_h >= FULL) begin
            n_heading = '0;
        end else begin
            n_heading = w_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_heading <= n_heading;
    end

    assign o_valid   = r_valid;
    assign o_heading = r_heading;

    `CHK_NEXT(a_scale_valid, i_ctl.valid, ##1 o_valid, "beat dropped in output stages")
    `CHK_IMPLY(a_heading_range, o_valid, o_heading < FULL, "heading reached a full turn")

endmodule

`default_nettype wire

[rtl/compass_heading_from_xy.sv]
// ----------------------------------------------------------------------------
// compass_heading_from_xy
// Compass heading from a horizontal magnetometer x/y pair, by pipelined
// vectoring CORDIC.
// ----------------------------------------------------------------------------
// The block takes one reading pair in every clock cycle and never raises
// busy. Each heading leaves on o_heading with o_valid high for one cycle,
// after passing one input stage, one register per CORDIC micro-rotation and
// two output stages for the degree scaling multiply and the rounding.
// Results come out in input order and must be taken when shown; there is no
// way to hold them. The heading is in 2^-ANGLE_FRAC_BITS degree, 0 north,
// 90 east.
// ----------------------------------------------------------------------------
`default_nettype none

module compass_heading_from_xy #(
    parameter int SAMPLE_BITS     = 16,
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int ROTATION_STAGES = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_field_x,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_field_y,
    output logic                                 o_valid,
    output logic [9+ANGLE_FRAC_BITS-1:0]         o_heading
);
    import chxy_pkg::*;

    localparam int HW      = 9 + ANGLE_FRAC_BITS;
    localparam int DW      = SAMPLE_BITS + GUARD_BITS + 3;
    localparam int NSTAGES = (ROTATION_STAGES < TABLE_LEN) ? ROTATION_STAGES : TABLE_LEN;

    logic signed [DW-1:0]  w_x   [NSTAGES+1];
    logic signed [DW-1:0]  w_y   [NSTAGES+1];
    logic [ANGLE_BITS-1:0] w_ang [NSTAGES+1];
    t_ctl                  w_ctl [NSTAGES+1];

    // Pipeline never stalls
    assign busy = 1'b0;

    // Input stage
    chxy_prerot #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DW          (DW)
    ) u_prerot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_field_x (i_field_x),
        .i_field_y (i_field_y),
        .o_x       (w_x[0]),
        .o_y       (w_y[0]),
        .o_ang     (w_ang[0]),
        .o_ctl     (w_ctl[0])
    );

    // Rotation stages
    for (genvar g = 0; g < NSTAGES; g++) begin : g_stage
        chxy_cordic_stage #(
            .DW    (DW),
            .STAGE (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_ang   (w_ang[g]),
            .i_ctl   (w_ctl[g]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_ang   (w_ang[g+1]),
            .o_ctl   (w_ctl[g+1])
        );
    end

    // Degree scaling and rounding
    chxy_scale #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .HW              (HW)
    ) u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ang     (w_ang[NSTAGES]),
        .i_ctl     (w_ctl[NSTAGES]),
        .o_valid   (o_valid),
        .o_heading (o_heading)
    );

endmodule

`default_nettype wire
